@@ sv/ffa_pkg.sv @@
// Shared types, codes and defaults of the first-fit allocator.
package ffa_pkg;

	localparam int HOLE_SLOTS_DEF = 16;
	localparam int PROC_IDS_DEF   = 256;
	localparam int ADDR_BITS_DEF  = 24;
	localparam int MEM_SIZE_W     = 25;
	localparam int MEM_SIZE_RST   = 65536;
	localparam int PID_W          = 8;
	localparam int TYPE_W         = 2;
	localparam int STATUS_W       = 3;

	typedef enum logic [TYPE_W-1:0] {
		REQ_ALLOC = 2'd0,
		REQ_FREE  = 2'd1,
		REQ_ADD   = 2'd2,
		REQ_NOP   = 2'd3
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 3'd0,
		ST_TAKEN   = 3'd1,
		ST_NOFIT   = 3'd2,
		ST_NOPROC  = 3'd3,
		ST_BADHOLE = 3'd4,
		ST_FULL    = 3'd5,
		ST_ZERO    = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_PREP,
		CMD_SCAN,
		CMD_SHIFT,
		CMD_MERGE,
		CMD_REWIND,
		CMD_FLUSH
	} dp_op_t;

	typedef struct packed {
		dp_op_t  op;
		logic    merge_wr;
		logic    finish;
		status_t code;
	} dp_cmd_t;

	typedef struct packed {
		req_t req;
		logic pid_bad;
		logic size_zero;
		logic taken;
		logic hole_bad;
		logic hit;
		logic exact;
		logic scan_end;
		logic shift_end;
		logic merge_end;
		logic fits;
		logic out_busy;
	} dp_sts_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_PREP,
		S_SCAN,
		S_SHIFT,
		S_COUNT,
		S_WRITE,
		S_DONE
	} ctrl_state_t;

endpackage

@@ sv/ffa_dp.sv @@
// Datapath of the allocator: hole table, allocation table, walk counters, result register.
module ffa_dp import ffa_pkg::*; #(
	parameter int HOLE_SLOTS = HOLE_SLOTS_DEF,
	parameter int PROC_IDS   = PROC_IDS_DEF,
	parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dp_cmd_t               cmd,
	output dp_sts_t               sts,
	input  logic [TYPE_W-1:0]     req_type,
	input  logic [PID_W-1:0]      proc_id,
	input  logic [ADDR_BITS:0]    req_size,
	input  logic [ADDR_BITS-1:0]  hole_start,
	input  logic                  cfg_valid,
	input  logic [MEM_SIZE_W-1:0] cfg_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [STATUS_W-1:0]   status,
	output logic [ADDR_BITS-1:0]  address
);

	localparam int IW = (HOLE_SLOTS > 1) ? $clog2(HOLE_SLOTS) : 1;
	localparam int CW = $clog2(HOLE_SLOTS + 1);
	localparam int MW = $clog2(HOLE_SLOTS + 2);
	localparam int PW = (PROC_IDS > 1) ? $clog2(PROC_IDS) : 1;
	localparam int SW = ADDR_BITS + 1;
	localparam int EW = (ADDR_BITS + 2 > MEM_SIZE_W + 1) ? ADDR_BITS + 2 : MEM_SIZE_W + 1;

	logic [ADDR_BITS-1:0]  hole_st_q [HOLE_SLOTS];
	logic [SW-1:0]         hole_sz_q [HOLE_SLOTS];
	logic [CW-1:0]         hole_cnt_q;
	logic [CW-1:0]         i_q;
	logic                  placed_q;
	logic [MW-1:0]         m_q;
	logic [ADDR_BITS-1:0]  acc_s_q, new_s_q, addr_q, hstart_q, alloc_st_rd_q, address_q;
	logic [SW-1:0]         acc_z_q, new_z_q, size_q, alloc_sz_rd_q;
	req_t                  req_q;
	logic [PID_W-1:0]      pid_q;
	logic [MEM_SIZE_W-1:0] mem_size_q;
	logic [PROC_IDS-1:0]   alloc_valid_q;
	logic [ADDR_BITS-1:0]  alloc_st_mem [PROC_IDS];
	logic [SW-1:0]         alloc_sz_mem [PROC_IDS];
	logic                  out_valid_q;
	status_t               status_q;

	logic [PW-1:0]         pid_idx;
	logic [IW-1:0]         iidx, nidx, wr_idx;
	logic [CW:0]           i_inc;
	logic [MW-1:0]         m_dec;
	logic [ADDR_BITS-1:0]  cur_st, elem_s;
	logic [SW-1:0]         cur_sz, elem_z;
	logic [EW-1:0]         add_end, acc_end;
	logic                  take_new, join_acc, scan_end, shift_end, hit, exact;

	assign pid_idx  = PW'(pid_q);
	assign iidx     = i_q[IW-1:0];
	assign i_inc    = {1'b0, i_q} + (CW+1)'(1);
	assign nidx     = i_inc[IW-1:0];
	assign m_dec    = m_q - MW'(1);
	assign wr_idx   = m_dec[IW-1:0];
	assign cur_st   = hole_st_q[iidx];
	assign cur_sz   = hole_sz_q[iidx];
	assign scan_end = i_q >= hole_cnt_q;
	assign shift_end = i_inc >= {1'b0, hole_cnt_q};
	assign hit      = cur_sz >= size_q;
	assign exact    = cur_sz == size_q;
	assign add_end  = EW'(hstart_q) + EW'(size_q);
	assign take_new = !placed_q && (scan_end || cur_st > new_s_q);
	assign elem_s   = take_new ? new_s_q : cur_st;
	assign elem_z   = take_new ? new_z_q : cur_sz;
	assign acc_end  = EW'(acc_s_q) + EW'(acc_z_q);
	assign join_acc = (m_q != '0) && (acc_end == EW'(elem_s));

	always_comb begin
		sts.req       = req_q;
		sts.pid_bad   = int'(pid_q) >= PROC_IDS;
		sts.size_zero = size_q == '0;
		sts.taken     = alloc_valid_q[pid_idx];
		sts.hole_bad  = (size_q == '0) || (add_end > EW'(mem_size_q))
			|| (add_end > (EW'(1) << ADDR_BITS));
		sts.hit       = hit;
		sts.exact     = exact;
		sts.scan_end  = scan_end;
		sts.shift_end = shift_end;
		sts.merge_end = placed_q && scan_end;
		sts.fits      = m_q <= MW'(HOLE_SLOTS);
		sts.out_busy  = out_valid_q && !out_ready;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hole_cnt_q    <= '0;
			i_q           <= '0;
			placed_q      <= 1'b0;
			m_q           <= '0;
			alloc_valid_q <= '0;
			mem_size_q    <= MEM_SIZE_W'(MEM_SIZE_RST);
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid)
				mem_size_q <= cfg_data;
			if (cmd.finish)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (cmd.op)
				CMD_LOAD: begin
					i_q <= '0;
				end
				CMD_PREP, CMD_REWIND: begin
					i_q      <= '0;
					placed_q <= 1'b0;
					m_q      <= '0;
				end
				CMD_SCAN: begin
					if (hit)
						alloc_valid_q[pid_idx] <= 1'b1;
					else
						i_q <= i_inc[CW-1:0];
				end
				CMD_SHIFT: begin
					if (shift_end)
						hole_cnt_q <= hole_cnt_q - CW'(1);
					else
						i_q <= i_inc[CW-1:0];
				end
				CMD_MERGE: begin
					if (take_new)
						placed_q <= 1'b1;
					else
						i_q <= i_inc[CW-1:0];
					if (!join_acc)
						m_q <= m_q + MW'(1);
				end
				CMD_FLUSH: begin
					hole_cnt_q <= CW'(m_q);
					if (req_q == REQ_FREE)
						alloc_valid_q[pid_idx] <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status_q  <= cmd.code;
			address_q <= addr_q;
		end
		case (cmd.op)
			CMD_LOAD: begin
				req_q    <= req_t'(req_type);
				pid_q    <= proc_id;
				size_q   <= req_size;
				hstart_q <= hole_start;
				addr_q   <= '0;
			end
			CMD_PREP: begin
				if (req_q == REQ_FREE) begin
					new_s_q <= alloc_st_rd_q;
					new_z_q <= alloc_sz_rd_q;
				end else begin
					new_s_q <= hstart_q;
					new_z_q <= size_q;
				end
			end
			CMD_SCAN: begin
				if (hit) begin
					addr_q <= cur_st;
					if (!exact) begin
						hole_st_q[iidx] <= cur_st + size_q[ADDR_BITS-1:0];
						hole_sz_q[iidx] <= cur_sz - size_q;
					end
				end
			end
			CMD_SHIFT: begin
				if (!shift_end) begin
					hole_st_q[iidx] <= hole_st_q[nidx];
					hole_sz_q[iidx] <= hole_sz_q[nidx];
				end
			end
			CMD_MERGE: begin
				if (join_acc) begin
					acc_z_q <= acc_z_q + elem_z;
				end else begin
					if (cmd.merge_wr && m_q != '0) begin
						hole_st_q[wr_idx] <= acc_s_q;
						hole_sz_q[wr_idx] <= acc_z_q;
					end
					acc_s_q <= elem_s;
					acc_z_q <= elem_z;
				end
			end
			CMD_FLUSH: begin
				hole_st_q[wr_idx] <= acc_s_q;
				hole_sz_q[wr_idx] <= acc_z_q;
			end
			default: begin
			end
		endcase
	end

	// allocation table
	always_ff @(posedge clk) begin
		if (cmd.op == CMD_SCAN && hit) begin
			alloc_st_mem[pid_idx] <= cur_st;
			alloc_sz_mem[pid_idx] <= size_q;
		end
		alloc_st_rd_q <= alloc_st_mem[pid_idx];
		alloc_sz_rd_q <= alloc_sz_mem[pid_idx];
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign address   = address_q;

endmodule

@@ sv/ffa_ctrl.sv @@
// Controller state machine of the allocator.
module ffa_ctrl import ffa_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	ctrl_state_t state_q, state_d;
	status_t     code_q, code_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			code_q  <= ST_OK;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		code_d  = code_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid)
					state_d = S_DECODE;
			end
			S_DECODE: begin
				state_d = S_DONE;
				case (sts.req)
					REQ_ALLOC: begin
						if (sts.pid_bad)
							code_d = ST_NOPROC;
						else if (sts.size_zero)
							code_d = ST_ZERO;
						else if (sts.taken)
							code_d = ST_TAKEN;
						else
							state_d = S_SCAN;
					end
					REQ_FREE: begin
						if (sts.pid_bad || !sts.taken)
							code_d = ST_NOPROC;
						else
							state_d = S_PREP;
					end
					REQ_ADD: begin
						if (sts.hole_bad)
							code_d = ST_BADHOLE;
						else
							state_d = S_PREP;
					end
					default: code_d = ST_OK;
				endcase
			end
			S_PREP: state_d = S_COUNT;
			S_SCAN: begin
				if (sts.scan_end) begin
					code_d  = ST_NOFIT;
					state_d = S_DONE;
				end else if (sts.hit) begin
					code_d  = ST_OK;
					state_d = sts.exact ? S_SHIFT : S_DONE;
				end
			end
			S_SHIFT: begin
				if (sts.shift_end)
					state_d = S_DONE;
			end
			S_COUNT: begin
				if (sts.merge_end) begin
					if (sts.fits) begin
						state_d = S_WRITE;
					end else begin
						code_d  = ST_FULL;
						state_d = S_DONE;
					end
				end
			end
			S_WRITE: begin
				if (sts.merge_end) begin
					code_d  = ST_OK;
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!sts.out_busy)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready     = 1'b0;
		cmd.op       = CMD_NONE;
		cmd.merge_wr = 1'b0;
		cmd.finish   = 1'b0;
		cmd.code     = code_q;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid)
					cmd.op = CMD_LOAD;
			end
			S_PREP:  cmd.op = CMD_PREP;
			S_SCAN: begin
				if (!sts.scan_end)
					cmd.op = CMD_SCAN;
			end
			S_SHIFT: cmd.op = CMD_SHIFT;
			S_COUNT: begin
				if (!sts.merge_end)
					cmd.op = CMD_MERGE;
				else if (sts.fits)
					cmd.op = CMD_REWIND;
			end
			S_WRITE: begin
				cmd.merge_wr = 1'b1;
				cmd.op       = sts.merge_end ? CMD_FLUSH : CMD_MERGE;
			end
			S_DONE: begin
				cmd.finish = !sts.out_busy;
			end
			default: begin
			end
		endcase
	end

endmodule

@@ sv/first_fit_allocator.sv @@
// First-fit allocator top level: controller, datapath and configuration port.
// Each request yields one result item (status and address). Requests are taken one at a time;
// a request that fails its checks goes from decode straight to the result. An allocate walks
// the hole table one entry a cycle until the first fit, and when it uses a hole up exactly it
// shifts the rest of the table down one entry a cycle. A free or add-hole walks the table twice,
// once to count the merged holes and once to write them back, one entry a cycle. The result
// register lets the next request be taken while a result still waits. The memory size may be
// written at any time the block is idle.
module first_fit_allocator import ffa_pkg::*; #(
	parameter int HOLE_SLOTS = HOLE_SLOTS_DEF,
	parameter int PROC_IDS   = PROC_IDS_DEF,
	parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [TYPE_W-1:0]     req_type,
	input  logic [PID_W-1:0]      proc_id,
	input  logic [ADDR_BITS:0]    req_size,
	input  logic [ADDR_BITS-1:0]  hole_start,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [MEM_SIZE_W-1:0] cfg_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [STATUS_W-1:0]   status,
	output logic [ADDR_BITS-1:0]  address
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg_ready = 1'b1;

	ffa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ffa_dp #(
		.HOLE_SLOTS (HOLE_SLOTS),
		.PROC_IDS   (PROC_IDS),
		.ADDR_BITS  (ADDR_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.req_type    (req_type),
		.proc_id     (proc_id),
		.req_size    (req_size),
		.hole_start  (hole_start),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.address     (address)
	);

endmodule

@@ tb/sv/ffa_checker.sv @@
// Checker for the first-fit allocator: watches the channels, predicts each result and compares.
module ffa_checker import ffa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [TYPE_W-1:0]     req_type,
	input  logic [PID_W-1:0]      proc_id,
	input  logic [24:0]           req_size,
	input  logic [23:0]           hole_start,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [MEM_SIZE_W-1:0] cfg_data,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [STATUS_W-1:0]   status,
	input  logic [23:0]           address,
	output int                    fail_count,
	output int                    pending,
	output int                    result_count
);

	typedef struct packed {
		status_t     st;
		logic [23:0] addr;
	} result_t;

	result_t     expected_q[$];
	logic [24:0] mem_limit;
	logic [63:0] gap_start[HOLE_SLOTS_DEF];
	logic [63:0] gap_size[HOLE_SLOTS_DEF];
	int          gap_count;
	logic        owned[PROC_IDS_DEF];
	logic [63:0] owned_start[PROC_IDS_DEF];
	logic [63:0] owned_size[PROC_IDS_DEF];

	assign pending = expected_q.size();

	// insert in address order after equal starts, merge touching holes; 0 if it overflows
	function automatic bit insert_gap(logic [63:0] s, logic [63:0] z);
		logic [63:0] ts[HOLE_SLOTS_DEF+1];
		logic [63:0] tz[HOLE_SLOTS_DEF+1];
		logic [63:0] ms[HOLE_SLOTS_DEF+1];
		logic [63:0] mz[HOLE_SLOTS_DEF+1];
		int n;
		int m;
		bit placed;
		n = 0;
		m = 0;
		placed = 0;
		for (int i = 0; i < gap_count; i++) begin
			if (!placed && gap_start[i] > s) begin
				ts[n] = s; tz[n] = z; n++; placed = 1;
			end
			ts[n] = gap_start[i]; tz[n] = gap_size[i]; n++;
		end
		if (!placed) begin
			ts[n] = s; tz[n] = z; n++;
		end
		for (int i = 0; i < n; i++) begin
			if (m > 0 && ms[m-1] + mz[m-1] == ts[i]) begin
				mz[m-1] += tz[i];
			end else begin
				ms[m] = ts[i]; mz[m] = tz[i]; m++;
			end
		end
		if (m > HOLE_SLOTS_DEF)
			return 0;
		for (int i = 0; i < m; i++) begin
			gap_start[i] = ms[i];
			gap_size[i] = mz[i];
		end
		gap_count = m;
		return 1;
	endfunction

	function automatic result_t serve_request(req_t t, int pid, logic [63:0] z, logic [63:0] hs);
		result_t r;
		r.st = ST_OK;
		r.addr = '0;
		case (t)
			REQ_ALLOC: begin
				if (z == 0) begin
					r.st = ST_ZERO;
				end else if (owned[pid]) begin
					r.st = ST_TAKEN;
				end else begin
					r.st = ST_NOFIT;
					for (int i = 0; i < gap_count; i++) begin
						if (gap_size[i] >= z) begin
							r.addr = gap_start[i][23:0];
							r.st = ST_OK;
							owned[pid] = 1;
							owned_start[pid] = gap_start[i];
							owned_size[pid] = z;
							if (gap_size[i] == z) begin
								for (int j = i; j < gap_count - 1; j++) begin
									gap_start[j] = gap_start[j+1];
									gap_size[j] = gap_size[j+1];
								end
								gap_count--;
							end else begin
								gap_start[i] += z;
								gap_size[i] -= z;
							end
							break;
						end
					end
				end
			end
			REQ_FREE: begin
				if (!owned[pid])
					r.st = ST_NOPROC;
				else if (!insert_gap(owned_start[pid], owned_size[pid]))
					r.st = ST_FULL;
				else
					owned[pid] = 0;
			end
			REQ_ADD: begin
				if (z == 0 || hs + z > mem_limit || hs + z > 64'h100_0000)
					r.st = ST_BADHOLE;
				else if (!insert_gap(hs, z))
					r.st = ST_FULL;
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t e;
		if (!arst_n) begin
			mem_limit = MEM_SIZE_W'(MEM_SIZE_RST);
			gap_count = 0;
			for (int i = 0; i < PROC_IDS_DEF; i++)
				owned[i] = 0;
			expected_q.delete();
			fail_count <= 0;
			result_count <= 0;
		end else begin
			if (out_valid && out_ready) begin
				result_count <= result_count + 1;
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected item status=%0d address=%h", $time, status, address);
					fail_count <= fail_count + 1;
				end else begin
					e = expected_q.pop_front();
					if (status !== e.st || address !== e.addr) begin
						$display("%0t: mismatch expected status=%0d address=%h, got status=%0d address=%h",
							$time, e.st, e.addr, status, address);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				mem_limit = cfg_data;
			if (in_valid && in_ready)
				expected_q.insert(expected_q.size(), serve_request(req_t'(req_type),
					int'(proc_id), 64'(req_size), 64'(hole_start)));
		end
	end

	final begin
		if (expected_q.size() != 0)
			$display("%0d items still expected at end", expected_q.size());
	end

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench top for the first-fit allocator: clock, reset, stimulus and verdict.
module tb_top;
	import ffa_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [TYPE_W-1:0]     req_type;
	logic [PID_W-1:0]      proc_id;
	logic [24:0]           req_size;
	logic [23:0]           hole_start;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [MEM_SIZE_W-1:0] cfg_data;
	logic                  out_valid;
	logic                  out_ready;
	logic [STATUS_W-1:0]   status;
	logic [23:0]           address;
	int                    fail_count;
	int                    pending;
	int                    result_count;
	int                    cycle_count;
	int                    sent_count;
	bit                    long_hold;

	localparam int CYCLE_LIMIT = 400000;

	first_fit_allocator uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .proc_id(proc_id), .req_size(req_size), .hole_start(hole_start),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.out_valid(out_valid), .out_ready(out_ready), .status(status), .address(address)
	);

	ffa_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .proc_id(proc_id), .req_size(req_size), .hole_start(hole_start),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.out_valid(out_valid), .out_ready(out_ready), .status(status), .address(address),
		.fail_count(fail_count), .pending(pending), .result_count(result_count)
	);

	initial clk = 0;
	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// receiver: own stall pattern, plus one long hold-off on request
	initial begin
		int k;
		out_ready = 0;
		k = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				out_ready <= 0;
				repeat (300) @(negedge clk);
				long_hold = 0;
			end
			k++;
			if ((k / 64) % 3 == 2)
				out_ready <= 1;
			else
				out_ready <= ($urandom_range(0, 3) != 0);
		end
	end

	task automatic send_req(req_t t, int pid, logic [24:0] z, logic [23:0] hs);
		req_type <= t;
		proc_id <= PID_W'(pid);
		req_size <= z;
		hole_start <= hs;
		in_valid <= 1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent_count++;
		@(negedge clk);
	endtask

	task automatic pause_gap();
		in_valid <= 0;
		repeat ($urandom_range(1, 6)) @(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (pending != 0)
			@(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic write_limit(logic [24:0] v);
		cfg_data <= v;
		cfg_valid <= 1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	// mostly small sizes so that holes get carved up and refilled
	function automatic logic [24:0] pick_size();
		case ($urandom_range(0, 9))
			0: return 25'($urandom_range(1, 25'h100_0000));
			1, 2: return 25'($urandom_range(1, 4096));
			default: return 25'($urandom_range(1, 64));
		endcase
	endfunction

	task automatic random_phase(int count, logic [24:0] span);
		int burst;
		int n;
		logic [23:0] hs;
		n = 0;
		while (n < count) begin
			burst = $urandom_range(1, 20);
			for (int b = 0; b < burst && n < count; b++) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: send_req(REQ_ALLOC, $urandom_range(0, 31), pick_size(),
						24'($urandom));
					4, 5, 6: send_req(REQ_FREE, $urandom_range(0, 31), 25'($urandom),
						24'($urandom));
					7, 8: begin
						hs = 24'($urandom_range(0, span - 1));
						send_req(REQ_ADD, $urandom, pick_size(), hs);
					end
					default: send_req(req_t'($urandom_range(0, 3)), $urandom, 25'($urandom),
						24'($urandom));
				endcase
				n++;
			end
			if ($urandom_range(0, 2) != 0)
				pause_gap();
		end
	endtask

	initial begin
		arst_n = 0;
		in_valid = 0;
		cfg_valid = 0;
		req_type = REQ_NOP;
		proc_id = 0;
		req_size = 0;
		hole_start = 0;
		cfg_data = MEM_SIZE_W'(MEM_SIZE_RST);
		cycle_count = 0;
		sent_count = 0;
		long_hold = 0;
		repeat (2) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: error codes, exact fit, coalescing, full table
		send_req(REQ_ALLOC, 0, 0, 0);
		send_req(REQ_ALLOC, 1, 10, 0);
		send_req(REQ_FREE, 255, 0, 0);
		send_req(REQ_ADD, 2, 0, 0);
		send_req(REQ_ADD, 2, 25'd65537, 0);
		send_req(REQ_ADD, 2, 25'h1FF_FFFF, 24'hFF_FFFF);
		send_req(REQ_NOP, 8'hFF, 25'h1FF_FFFF, 24'hFF_FFFF);
		send_req(REQ_ADD, 0, 100, 0);
		send_req(REQ_ADD, 0, 100, 100);
		send_req(REQ_ADD, 0, 50, 50);
		send_req(REQ_ALLOC, 255, 200, 0);
		send_req(REQ_ALLOC, 255, 5, 0);
		send_req(REQ_ALLOC, 7, 50, 0);
		send_req(REQ_ALLOC, 7, 1, 0);
		send_req(REQ_FREE, 255, 0, 0);
		send_req(REQ_FREE, 7, 0, 0);
		for (int i = 0; i < 17; i++)
			send_req(REQ_ADD, 0, 1, 24'(1000 + 2 * i));
		drain();

		write_limit(25'h100_0000);
		send_req(REQ_ADD, 0, 25'h100_0000, 0);
		random_phase(400, 25'h100_0000);
		long_hold = 1;
		random_phase(100, 25'h100_0000);
		drain();

		write_limit(1);
		send_req(REQ_ADD, 0, 1, 0);
		send_req(REQ_ADD, 0, 1, 1);
		random_phase(100, 2);
		drain();

		write_limit(25'h1FF_FFFF);
		random_phase(450, 25'h100_0000);
		drain();

		write_limit(4096);
		random_phase(450, 4096);
		drain();

		$display("%0d requests sent, %0d results checked over five memory sizes", sent_count,
			result_count);
		if (fail_count == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
